>>> sv/shsd_pkg.sv
// Shared constants, types and lookup functions for the stepper speed display block.
package shsd_pkg;

    localparam int NUM_DIGITS = 8;
    localparam int SCAN_W     = 3;
    localparam int PADDR_W    = 4;

    localparam logic [4:0] SPEED_MIN  = 5'd3;
    localparam logic [4:0] SPEED_WRAP = 5'd20;
    localparam logic [4:0] SPEED_TEN  = 5'd10;
    localparam logic [9:0] CYCLES_MAX = 10'd1023;

    localparam logic [SCAN_W-1:0] SCAN_LAST = SCAN_W'(NUM_DIGITS - 1);

    localparam logic [1:0] REG_TOTAL_CYCLES   = 2'd0;
    localparam logic [1:0] REG_DEBOUNCE_TICKS = 2'd1;
    localparam logic [1:0] REG_SCAN_PERIOD    = 2'd2;

    localparam logic [9:0] RST_TOTAL_CYCLES   = 10'd512;
    localparam logic [7:0] RST_DEBOUNCE_TICKS = 8'd10;
    localparam logic [7:0] RST_SCAN_PERIOD    = 8'd2;

    typedef struct packed {
        logic [9:0] total_cycles;
        logic [7:0] debounce_ticks;
        logic [7:0] scan_period;
    } t_cfg;

    function automatic logic [3:0] coil_code(input logic [2:0] phase);
        logic [3:0] code;
        case (phase)
            3'd0:    code = 4'h1;
            3'd1:    code = 4'h3;
            3'd2:    code = 4'h2;
            3'd3:    code = 4'h6;
            3'd4:    code = 4'h4;
            3'd5:    code = 4'hC;
            3'd6:    code = 4'h8;
            default: code = 4'h9;
        endcase
        return code;
    endfunction

    function automatic logic [7:0] seg_code(input logic [3:0] digit);
        logic [7:0] code;
        case (digit)
            4'd0:    code = 8'h3f;
            4'd1:    code = 8'h06;
            4'd2:    code = 8'h5b;
            4'd3:    code = 8'h4f;
            4'd4:    code = 8'h66;
            4'd5:    code = 8'h6d;
            4'd6:    code = 8'h7d;
            4'd7:    code = 8'h07;
            4'd8:    code = 8'h7f;
            4'd9:    code = 8'h6f;
            default: code = 8'h00;
        endcase
        return code;
    endfunction

endpackage

>>> sv/shsd_apb_regs.sv
// APB configuration register file for the stepper speed display block.
module shsd_apb_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [shsd_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output shsd_pkg::t_cfg               o_cfg
);
    import shsd_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.total_cycles   <= RST_TOTAL_CYCLES;
            r_cfg.debounce_ticks <= RST_DEBOUNCE_TICKS;
            r_cfg.scan_period    <= RST_SCAN_PERIOD;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_TOTAL_CYCLES:   r_cfg.total_cycles   <= pwdata[9:0];
                REG_DEBOUNCE_TICKS: r_cfg.debounce_ticks <= pwdata[7:0];
                REG_SCAN_PERIOD:    r_cfg.scan_period    <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_TOTAL_CYCLES:   prdata = {22'd0, r_cfg.total_cycles};
            REG_DEBOUNCE_TICKS: prdata = {24'd0, r_cfg.debounce_ticks};
            REG_SCAN_PERIOD:    prdata = {24'd0, r_cfg.scan_period};
            default:            prdata = 32'd0;
        endcase
    end

endmodule

>>> sv/stepper_halfstep_speed_display_top.sv
// Top level: half-step stepper driver with debounced speed button and scanned display.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+----------------------------------------
//  tick in | in        | i_in_valid / o_in_ready    | i_button_low
//  result  | out       | o_out_valid / i_out_ready  | o_coil_pattern, o_running,
//          |           |                            | o_digit_select, o_segment_bits,
//          |           |                            | o_speed_level
//  config  | in        | APB psel/penable/pwrite    | paddr, pwdata, prdata
//
// One tick transaction per cycle while o_in_ready is high; its result is registered and shows in the next cycle.
// All state updates in the cycle a tick is accepted; the result register is the only stage.
// o_in_ready is high while the result register is empty or being drained.
// Reset (synchronous, active low) clears the state, sets the speed to SPEED_MIN and loads register defaults; no sweep.
module stepper_halfstep_speed_display_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_button_low,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [3:0]                   o_coil_pattern,
    output logic                         o_running,
    output logic [7:0]                   o_digit_select,
    output logic [7:0]                   o_segment_bits,
    output logic [4:0]                   o_speed_level,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [shsd_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import shsd_pkg::*;

    t_cfg cfg;

    shsd_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    logic [2:0]        r_phase, n_phase;
    logic [4:0]        r_hold, n_hold;
    logic [9:0]        r_cycles, n_cycles;
    logic [4:0]        r_speed, n_speed;
    logic              r_btn_prev;
    logic              r_db_active, n_db_active;
    logic [7:0]        r_db_count, n_db_count;
    logic [SCAN_W-1:0] r_scan_idx, n_scan_idx;
    logic [7:0]        r_scan_timer, n_scan_timer;

    logic       r_out_valid;
    logic [3:0] r_coil, n_coil;
    logic       r_run, n_run;
    logic [7:0] r_dsel, n_dsel;
    logic [7:0] r_seg, n_seg;
    logic [4:0] r_spd_out;

    logic       accept;
    logic [7:0] db_limit, db_inc, scan_limit, scan_inc;
    logic [4:0] speed_inc, hold_load;
    logic [3:0] units;
    logic [3:0] tens;

    assign o_in_ready     = !r_out_valid || i_out_ready;
    assign accept         = i_in_valid && o_in_ready;
    assign o_out_valid    = r_out_valid;
    assign o_coil_pattern = r_coil;
    assign o_running      = r_run;
    assign o_digit_select = r_dsel;
    assign o_segment_bits = r_seg;
    assign o_speed_level  = r_spd_out;

    // button debounce and speed step
    always_comb begin
        db_limit    = (cfg.debounce_ticks == 8'd0) ? 8'd1 : cfg.debounce_ticks;
        db_inc      = r_db_count + 8'd1;
        speed_inc   = r_speed + 5'd1;
        n_db_active = r_db_active;
        n_db_count  = r_db_count;
        n_speed     = r_speed;
        if (r_db_active) begin
            n_db_count = db_inc;
            if (db_inc >= db_limit || db_inc == 8'd0) begin
                n_db_active = 1'b0;
                n_db_count  = 8'd0;
                if (i_button_low) begin
                    n_speed = (speed_inc == SPEED_WRAP || speed_inc < SPEED_MIN) ?
                              SPEED_MIN : speed_inc;
                end
            end
        end else if (i_button_low && !r_btn_prev) begin
            n_db_active = 1'b1;
            n_db_count  = 8'd0;
        end
    end

    // motor phase walk
    always_comb begin
        hold_load = (n_speed == 5'd0) ? 5'd1 : n_speed;
        n_phase   = r_phase;
        n_hold    = r_hold;
        n_cycles  = r_cycles;
        if (r_cycles >= cfg.total_cycles) begin
            n_run  = 1'b0;
            n_coil = (r_phase == 3'd0 && r_cycles == 10'd0) ? 4'h0 :
                     coil_code(r_phase - 3'd1);
        end else begin
            n_run  = 1'b1;
            n_coil = coil_code(r_phase);
            n_hold = ((r_hold == 5'd0) ? hold_load : r_hold) - 5'd1;
            if (n_hold == 5'd0) begin
                n_phase = r_phase + 3'd1;
                if (n_phase == 3'd0 && r_cycles < CYCLES_MAX) begin
                    n_cycles = r_cycles + 10'd1;
                end
            end
        end
    end

    // display scan
    always_comb begin
        if (n_speed >= SPEED_TEN) begin
            tens  = 4'd1;
            units = 4'(n_speed - SPEED_TEN);
        end else begin
            tens  = 4'd0;
            units = n_speed[3:0];
        end
        case (r_scan_idx)
            SCAN_W'(0): n_seg = seg_code(tens);
            SCAN_W'(1): n_seg = seg_code(units);
            default:    n_seg = 8'h00;
        endcase
        n_dsel = ~(8'd1 << r_scan_idx);

        scan_limit   = (cfg.scan_period == 8'd0) ? 8'd1 : cfg.scan_period;
        scan_inc     = r_scan_timer + 8'd1;
        n_scan_timer = scan_inc;
        n_scan_idx   = r_scan_idx;
        if (scan_inc >= scan_limit || scan_inc == 8'd0) begin
            n_scan_timer = 8'd0;
            n_scan_idx   = (r_scan_idx >= SCAN_LAST) ? '0 : r_scan_idx + SCAN_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= 3'd0;
            r_hold       <= 5'd0;
            r_cycles     <= 10'd0;
            r_speed      <= SPEED_MIN;
            r_btn_prev   <= 1'b0;
            r_db_active  <= 1'b0;
            r_db_count   <= 8'd0;
            r_scan_idx   <= '0;
            r_scan_timer <= 8'd0;
        end else if (accept) begin
            r_phase      <= n_phase;
            r_hold       <= n_hold;
            r_cycles     <= n_cycles;
            r_speed      <= n_speed;
            r_btn_prev   <= i_button_low;
            r_db_active  <= n_db_active;
            r_db_count   <= n_db_count;
            r_scan_idx   <= n_scan_idx;
            r_scan_timer <= n_scan_timer;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_coil    <= n_coil;
            r_run     <= n_run;
            r_dsel    <= n_dsel;
            r_seg     <= n_seg;
            r_spd_out <= n_speed;
        end
    end

endmodule
